>>> rtl/core/motion_command_supervisor_core_defines.svh
// assertion macros shared by the motion command supervisor rtl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef MOTION_COMMAND_SUPERVISOR_CORE_DEFINES_SVH
`define MOTION_COMMAND_SUPERVISOR_CORE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define MCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define MCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mcs_pkg.sv
// shared types and codes for the motion command supervisor
// no dependencies
`timescale 1ns / 1ps

package mcs_pkg;

    // configuration port geometry
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [14:0] VX_LIMIT_RST      = 15'd100;
    localparam logic [14:0] W_LIMIT_RST       = 15'd500;
    localparam logic [15:0] TIMEOUT_MIN_RST   = 16'd50;
    localparam logic [15:0] TIMEOUT_MAX_RST   = 16'd500;
    localparam logic [15:0] TIMEOUT_DEF_RST   = 16'd300;
    localparam logic [15:0] TELEM_PERIOD_RST  = 16'd100;

    // register indexes
    typedef enum logic [2:0] {
        CFG_VX_LIMIT     = 3'd0,
        CFG_W_LIMIT      = 3'd1,
        CFG_TIMEOUT_MIN  = 3'd2,
        CFG_TIMEOUT_MAX  = 3'd3,
        CFG_TIMEOUT_DEF  = 3'd4,
        CFG_TELEM_PERIOD = 3'd5
    } t_cfg_idx;

    // event codes
    typedef enum logic [2:0] {
        FN_TICK      = 3'd0,
        FN_FRAME_OK  = 3'd1,
        FN_PARSE_ERR = 3'd2,
        FN_LINE_OVF  = 3'd3,
        FN_RX_FAULT  = 3'd4,
        FN_DESYNC    = 3'd5,
        FN_ENCODER   = 3'd6
    } t_func;

    // frame types
    typedef enum logic [2:0] {
        FT_PING    = 3'd0,
        FT_DISARM  = 3'd1,
        FT_ARM     = 3'd2,
        FT_CMD     = 3'd3,
        FT_UNKNOWN = 3'd4
    } t_frame;

    // parse fault codes
    typedef enum logic [2:0] {
        PF_MISSING_SEQ   = 3'd0,
        PF_MISSING_FIELD = 3'd1,
        PF_RANGE         = 3'd2,
        PF_TIMEOUT       = 3'd3,
        PF_BAD_TYPE      = 3'd4
    } t_parse_fault;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_PONG  = 2'd2,
        KIND_TELEM = 2'd3
    } t_kind;

    // message types in results
    typedef enum logic [2:0] {
        MSG_PING    = 3'd0,
        MSG_DISARM  = 3'd1,
        MSG_ARM     = 3'd2,
        MSG_CMD     = 3'd3,
        MSG_UNKNOWN = 3'd4,
        MSG_LINK    = 3'd5
    } t_msg;

    // error codes
    typedef enum logic [3:0] {
        ERR_NONE          = 4'd0,
        ERR_MISSING_SEQ   = 4'd1,
        ERR_MISSING_FIELD = 4'd2,
        ERR_RANGE         = 4'd3,
        ERR_TIMEOUT       = 4'd4,
        ERR_BAD_TYPE      = 4'd5,
        ERR_NOT_ARMED     = 4'd6,
        ERR_LINE_OVF      = 4'd7,
        ERR_DESYNC        = 4'd8
    } t_err;

    // robot modes
    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_ARMED    = 2'd1,
        MODE_FAULT    = 2'd2
    } t_mode;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [14:0] vx_limit;
        logic [14:0] w_limit;
        logic [15:0] timeout_min;
        logic [15:0] timeout_max;
        logic [15:0] timeout_default;
        logic [15:0] telemetry_period;
    } t_cfg;

    // one input request
    typedef struct packed {
        logic [2:0]         func;
        logic [2:0]         frame_type;
        logic [31:0]        seq;
        logic signed [15:0] vx_req;
        logic signed [15:0] w_req;
        logic [15:0]        timeout_req;
        logic [2:0]         parse_fault;
        logic signed [31:0] left_rate;
        logic signed [31:0] right_rate;
    } t_item;

    // one result
    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        reply_seq;
        logic [2:0]         msg_type;
        logic [3:0]         err_code;
        logic [31:0]        time_ms;
        logic [1:0]         robot_mode;
        logic signed [15:0] vx_now;
        logic signed [15:0] w_now;
        logic signed [31:0] left_now;
        logic signed [31:0] right_now;
        logic [31:0]        fault_count;
    } t_result;

endpackage

>>> rtl/core/mcs_cfg_regs.sv
// apb-style configuration registers of the motion command supervisor
// depends on mcs_pkg
`timescale 1ns / 1ps

module mcs_cfg_regs import mcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg,
    output logic                  o_load_default
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_cfg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_cfg_idx'(paddr[CFG_ADDR_W-1:2]);

    // register writes, unmapped indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vx_limit         <= VX_LIMIT_RST;
            r_cfg.w_limit          <= W_LIMIT_RST;
            r_cfg.timeout_min      <= TIMEOUT_MIN_RST;
            r_cfg.timeout_max      <= TIMEOUT_MAX_RST;
            r_cfg.timeout_default  <= TIMEOUT_DEF_RST;
            r_cfg.telemetry_period <= TELEM_PERIOD_RST;
        end else if (wr_en) begin
            unique case (idx)
                CFG_VX_LIMIT:     r_cfg.vx_limit         <= pwdata[14:0];
                CFG_W_LIMIT:      r_cfg.w_limit          <= pwdata[14:0];
                CFG_TIMEOUT_MIN:  r_cfg.timeout_min      <= pwdata[15:0];
                CFG_TIMEOUT_MAX:  r_cfg.timeout_max      <= pwdata[15:0];
                CFG_TIMEOUT_DEF:  r_cfg.timeout_default  <= pwdata[15:0];
                CFG_TELEM_PERIOD: r_cfg.telemetry_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            CFG_VX_LIMIT:     prdata = {17'd0, r_cfg.vx_limit};
            CFG_W_LIMIT:      prdata = {17'd0, r_cfg.w_limit};
            CFG_TIMEOUT_MIN:  prdata = {16'd0, r_cfg.timeout_min};
            CFG_TIMEOUT_MAX:  prdata = {16'd0, r_cfg.timeout_max};
            CFG_TIMEOUT_DEF:  prdata = {16'd0, r_cfg.timeout_default};
            CFG_TELEM_PERIOD: prdata = {16'd0, r_cfg.telemetry_period};
            default:          prdata = '0;
        endcase
    end

    // a default timeout write also reloads the live timeout
    assign o_load_default = wr_en && (idx == CFG_TIMEOUT_DEF);
    assign o_cfg          = r_cfg;

endmodule

>>> rtl/core/motion_command_supervisor_core.sv
// motion command supervisor: input register, single-pass event logic, result register
// a request's result is registered in the result register when the request advances
// throughput: one request per clock while the result side takes results
// reset: synchronous active low, clears mode, velocities, timers, counters, valids
// registers return to their defaults, cmd timeout to the default timeout
`timescale 1ns / 1ps
`include "motion_command_supervisor_core_defines.svh"

module motion_command_supervisor_core import mcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_func,
    input  logic [2:0]            i_frame_type,
    input  logic [31:0]           i_seq,
    input  logic signed [15:0]    i_vx_req,
    input  logic signed [15:0]    i_w_req,
    input  logic [15:0]           i_timeout_req,
    input  logic [2:0]            i_parse_fault,
    input  logic signed [31:0]    i_left_rate,
    input  logic signed [31:0]    i_right_rate,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_kind,
    output logic [31:0]           o_reply_seq,
    output logic [2:0]            o_msg_type,
    output logic [3:0]            o_err_code,
    output logic [31:0]           o_time_ms,
    output logic [1:0]            o_robot_mode,
    output logic signed [15:0]    o_vx_now,
    output logic signed [15:0]    o_w_now,
    output logic signed [31:0]    o_left_now,
    output logic signed [31:0]    o_right_now,
    output logic [31:0]           o_fault_count,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg cfg;
    logic load_default;

    mcs_cfg_regs u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_cfg          (cfg),
        .o_load_default (load_default)
    );

    // pipeline registers
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    in_accept;
    logic    advance;

    // supervisor state
    logic               r_armed,       n_armed;
    logic [31:0]        r_echo_seq,    n_echo_seq;
    logic signed [15:0] r_vx_cmd,      n_vx_cmd;
    logic signed [15:0] r_w_cmd,       n_w_cmd;
    logic [15:0]        r_cmd_timeout, n_cmd_timeout;
    logic [31:0]        r_now_ms,      n_now_ms;
    logic [31:0]        r_last_cmd_ms, n_last_cmd_ms;
    logic [31:0]        r_last_tel_ms, n_last_tel_ms;
    logic [31:0]        r_err_total,   n_err_total;
    logic signed [31:0] r_left_store,  n_left_store;
    logic signed [31:0] r_right_store, n_right_store;

    logic               res_valid;
    t_result            res;

    // handshake: the request stage moves when the result stage has room
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.func        <= i_func;
            r_in.frame_type  <= i_frame_type;
            r_in.seq         <= i_seq;
            r_in.vx_req      <= i_vx_req;
            r_in.w_req       <= i_w_req;
            r_in.timeout_req <= i_timeout_req;
            r_in.parse_fault <= i_parse_fault;
            r_in.left_rate   <= i_left_rate;
            r_in.right_rate  <= i_right_rate;
        end
    end

    // event decode helpers
    logic [2:0]         ftype;
    logic signed [16:0] vx_ext, w_ext, vl_pos, wl_pos;
    logic               vel_bad, tmo_bad;
    logic [3:0]         pf_code;
    logic [31:0]        since_cmd, since_tel;

    always_comb begin
        ftype   = (r_in.frame_type > FT_UNKNOWN) ? FT_UNKNOWN : r_in.frame_type;
        vx_ext  = {r_in.vx_req[15], r_in.vx_req};
        w_ext   = {r_in.w_req[15], r_in.w_req};
        vl_pos  = {2'b00, cfg.vx_limit};
        wl_pos  = {2'b00, cfg.w_limit};
        vel_bad = (vx_ext < -vl_pos) || (vx_ext > vl_pos)
               || (w_ext < -wl_pos) || (w_ext > wl_pos);
        tmo_bad = (r_in.timeout_req < cfg.timeout_min)
               || (r_in.timeout_req > cfg.timeout_max);
        unique case (r_in.parse_fault)
            PF_MISSING_SEQ:   pf_code = ERR_MISSING_SEQ;
            PF_MISSING_FIELD: pf_code = ERR_MISSING_FIELD;
            PF_RANGE:         pf_code = ERR_RANGE;
            PF_TIMEOUT:       pf_code = ERR_TIMEOUT;
            default:          pf_code = ERR_BAD_TYPE;
        endcase
    end

    // event handling, then watchdog, then telemetry on ticks
    always_comb begin
        n_armed       = r_armed;
        n_echo_seq    = r_echo_seq;
        n_vx_cmd      = r_vx_cmd;
        n_w_cmd       = r_w_cmd;
        n_cmd_timeout = r_cmd_timeout;
        n_now_ms      = r_now_ms;
        n_last_cmd_ms = r_last_cmd_ms;
        n_last_tel_ms = r_last_tel_ms;
        n_err_total   = r_err_total;
        n_left_store  = r_left_store;
        n_right_store = r_right_store;
        res_valid     = 1'b0;
        res           = '0;

        unique case (r_in.func)
            FN_TICK: begin
                n_now_ms = r_now_ms + 32'd1;
            end
            FN_FRAME_OK: begin
                res_valid     = 1'b1;
                res.reply_seq = r_in.seq;
                res.msg_type  = ftype;
                if (ftype == FT_PING) begin
                    n_echo_seq = r_in.seq;
                    res.kind   = KIND_PONG;
                    res.msg_type = MSG_PING;
                end else if (ftype == FT_DISARM || ftype == FT_ARM) begin
                    n_vx_cmd   = '0;
                    n_w_cmd    = '0;
                    n_armed    = (ftype == FT_ARM);
                    n_echo_seq = r_in.seq;
                    res.kind   = KIND_ACK;
                end else if (ftype == FT_CMD) begin
                    res.msg_type = MSG_CMD;
                    if (vel_bad) begin
                        n_err_total  = r_err_total + 32'd1;
                        res.kind     = KIND_ERROR;
                        res.err_code = ERR_RANGE;
                    end else if (tmo_bad) begin
                        n_err_total  = r_err_total + 32'd1;
                        res.kind     = KIND_ERROR;
                        res.err_code = ERR_TIMEOUT;
                    end else if (!r_armed) begin
                        n_err_total  = r_err_total + 32'd1;
                        res.kind     = KIND_ERROR;
                        res.err_code = ERR_NOT_ARMED;
                    end else begin
                        n_echo_seq    = r_in.seq;
                        n_vx_cmd      = r_in.vx_req;
                        n_w_cmd       = r_in.w_req;
                        n_cmd_timeout = r_in.timeout_req;
                        n_last_cmd_ms = r_now_ms;
                        res.kind      = KIND_ACK;
                    end
                end else begin
                    // unknown frame type
                    n_err_total   = r_err_total + 32'd1;
                    res.kind      = KIND_ERROR;
                    res.reply_seq = '0;
                    res.msg_type  = MSG_UNKNOWN;
                    res.err_code  = ERR_BAD_TYPE;
                end
            end
            FN_PARSE_ERR: begin
                n_err_total   = r_err_total + 32'd1;
                res_valid     = 1'b1;
                res.kind      = KIND_ERROR;
                res.reply_seq = r_in.seq;
                res.msg_type  = ftype;
                res.err_code  = pf_code;
            end
            FN_LINE_OVF: begin
                n_err_total  = r_err_total + 32'd1;
                res_valid    = 1'b1;
                res.kind     = KIND_ERROR;
                res.msg_type = MSG_LINK;
                res.err_code = ERR_LINE_OVF;
            end
            FN_RX_FAULT: begin
                n_err_total = r_err_total + 32'd1;
            end
            FN_DESYNC: begin
                res_valid    = 1'b1;
                res.kind     = KIND_ERROR;
                res.msg_type = MSG_LINK;
                res.err_code = ERR_DESYNC;
            end
            FN_ENCODER: begin
                n_left_store  = r_in.left_rate;
                n_right_store = r_in.right_rate;
            end
            default: ;
        endcase

        res.time_ms = n_now_ms;

        // command watchdog
        since_cmd = n_now_ms - n_last_cmd_ms;
        if (n_armed && (since_cmd >= {16'd0, n_cmd_timeout})) begin
            n_vx_cmd = '0;
            n_w_cmd  = '0;
        end

        // telemetry period
        since_tel = n_now_ms - r_last_tel_ms;
        if ((r_in.func == FN_TICK) && (since_tel >= {16'd0, cfg.telemetry_period})) begin
            n_last_tel_ms   = n_now_ms;
            res_valid       = 1'b1;
            res.kind        = KIND_TELEM;
            res.reply_seq   = n_echo_seq;
            res.msg_type    = MSG_PING;
            res.err_code    = ERR_NONE;
            res.robot_mode  = n_armed ? MODE_ARMED : MODE_DISARMED;
            res.vx_now      = n_vx_cmd;
            res.w_now       = n_w_cmd;
            res.left_now    = n_left_store;
            res.right_now   = n_right_store;
            res.fault_count = n_err_total;
        end
    end

    // state update on each processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= 1'b0;
            r_echo_seq    <= '0;
            r_vx_cmd      <= '0;
            r_w_cmd       <= '0;
            r_now_ms      <= '0;
            r_last_cmd_ms <= '0;
            r_last_tel_ms <= '0;
            r_err_total   <= '0;
            r_left_store  <= '0;
            r_right_store <= '0;
        end else if (advance) begin
            r_armed       <= n_armed;
            r_echo_seq    <= n_echo_seq;
            r_vx_cmd      <= n_vx_cmd;
            r_w_cmd       <= n_w_cmd;
            r_now_ms      <= n_now_ms;
            r_last_cmd_ms <= n_last_cmd_ms;
            r_last_tel_ms <= n_last_tel_ms;
            r_err_total   <= n_err_total;
            r_left_store  <= n_left_store;
            r_right_store <= n_right_store;
        end
    end

    // live command timeout; the user must write registers only while idle, which
    // is not enforced; a default timeout write loads the written value directly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_timeout <= TIMEOUT_DEF_RST;
        end else if (load_default) begin
            r_cmd_timeout <= pwdata[15:0];
        end else if (advance) begin
            r_cmd_timeout <= n_cmd_timeout;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_reply_seq   = r_out.reply_seq;
    assign o_msg_type    = r_out.msg_type;
    assign o_err_code    = r_out.err_code;
    assign o_time_ms     = r_out.time_ms;
    assign o_robot_mode  = r_out.robot_mode;
    assign o_vx_now      = r_out.vx_now;
    assign o_w_now       = r_out.w_now;
    assign o_left_now    = r_out.left_now;
    assign o_right_now   = r_out.right_now;
    assign o_fault_count = r_out.fault_count;

    // checks
    `MCS_ASSERT_NOW(a_disarmed_still, !r_armed, (r_vx_cmd == '0) && (r_w_cmd == '0), "velocity while disarmed")
    `MCS_ASSERT_NOW(a_err_code, o_out_valid, (o_kind == KIND_ERROR) == (o_err_code != ERR_NONE), "error code does not match kind")
    `MCS_ASSERT_NOW(a_status_zero, o_out_valid && (o_kind != KIND_TELEM), (o_fault_count == '0) && (o_vx_now == '0) && (o_robot_mode == MODE_DISARMED), "status outside telemetry")
    `MCS_ASSERT_NEXT(a_hold_request, r_in_valid && !advance, r_in_valid && $stable(r_in.seq), "pending request lost")

endmodule
